// ===== rtl/round_robin_thread_scheduler_macros.svh =====
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by files that assert.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication under reset.
`define RRTS_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication under reset.
`define RRTS_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== rtl/rrts_pkg.sv =====
// Shared types, codes and sizes for the round-robin thread scheduler.
// Depends on nothing.
package rrts_pkg;

	localparam int MAX_THREADS = 16;
	localparam int ID_W        = 4;
	localparam int NUM_IDS     = 16;
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);
	localparam int QIDX_W      = $clog2(MAX_THREADS);
	localparam int TIME_W      = 16;
	localparam int CFG_W       = 16;

	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_ADD    = 3'd1;
	localparam logic [2:0] FN_REMOVE = 3'd2;
	localparam logic [2:0] FN_START  = 3'd3;
	localparam logic [2:0] FN_STATUS = 3'd4;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_DESTROY = 2'd1;
	localparam logic [1:0] EV_SWITCH  = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	localparam logic [1:0] ST_RUNNABLE = 2'd0;
	localparam logic [1:0] ST_ZOMBIE   = 2'd1;

	localparam logic CFG_QUANTUM = 1'b0;
	localparam logic CFG_IDLE    = 1'b1;

	localparam logic [TIME_W-1:0] QUANTUM_RST = 16'd10;

	typedef struct packed {
		logic [2:0]      func;
		logic [ID_W-1:0] thread_id;
		logic [1:0]      new_status;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      event_kind;
		logic [ID_W-1:0] subject_thread;
		logic [ID_W-1:0] previous_thread;
		logic            previous_valid;
		logic            last;
	} out_item_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_RESULT,
		EM_REJECT,
		EM_DESTROY,
		EM_FINISH
	} emit_t;

	typedef struct packed {
		logic  accept;
		logic  dec_time;
		logic  push_tid;
		logic  rem_load;
		logic  rotate;
		logic  write_status;
		logic  clr_rvalid;
		logic  pop_sel;
		logic  sel_empty;
		logic  st_addr_run;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       count_zero;
		logic       count_full;
		logic       time_le1;
		logic       run_is_tid;
		logic       rem_zero;
		logic       st_zombie;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/rrts_ctrl.sv =====
// Sequencer for the scheduler: walks each transaction through its steps.
// Depends on rrts_pkg.
module rrts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rrts_pkg::stat_t stat,
	output rrts_pkg::cmd_t  cmd
);
	import rrts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_REMOVE,
		S_ELECT,
		S_CHECK,
		S_FINISH,
		S_RESULT
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.emit = EM_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.func)
					FN_TICK: begin
						cmd.dec_time = 1'b1;
						state_d      = stat.time_le1 ? S_ELECT : S_RESULT;
					end
					FN_ADD: begin
						if (!stat.count_full) begin
							cmd.push_tid = 1'b1;
							state_d      = S_RESULT;
						end else if (stat.out_free) begin
							cmd.emit = EM_REJECT;
							state_d  = S_IDLE;
						end
					end
					FN_REMOVE: begin
						if (stat.run_is_tid) begin
							cmd.clr_rvalid = 1'b1;
							state_d        = S_ELECT;
						end else begin
							cmd.rem_load = 1'b1;
							state_d      = S_REMOVE;
						end
					end
					FN_START:  state_d = S_ELECT;
					FN_STATUS: begin
						cmd.write_status = 1'b1;
						state_d          = S_RESULT;
					end
					default:   state_d = S_RESULT;
				endcase
			end
			S_REMOVE: begin
				if (stat.rem_zero) begin
					state_d = S_RESULT;
				end else begin
					cmd.rotate = 1'b1;
				end
			end
			S_ELECT: begin
				cmd.st_addr_run = 1'b1;
				if (stat.count_zero) begin
					cmd.sel_empty = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.pop_sel = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.st_zombie) begin
					state_d = S_FINISH;
				end else if (stat.out_free) begin
					cmd.emit = EM_DESTROY;
					state_d  = S_ELECT;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.emit = EM_FINISH;
					state_d  = S_IDLE;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.emit = EM_RESULT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/rrts_dp.sv =====
// Scheduler datapath: ready queue, status table, running thread, quantum
// timer, configuration and result register. Depends on rrts_pkg.
module rrts_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rrts_pkg::in_item_t        req,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [rrts_pkg::CFG_W-1:0] cfg_data,
	input  rrts_pkg::cmd_t            cmd,
	output rrts_pkg::stat_t           stat,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rrts_pkg::out_item_t       rsp
);
	import rrts_pkg::*;

	logic [TIME_W-1:0] quantum_q;
	logic [ID_W-1:0]   idle_q;
	in_item_t          item_q;
	logic [ID_W-1:0]   queue_q [MAX_THREADS];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [ID_W-1:0]   run_q;
	logic              rvalid_q;
	logic [TIME_W-1:0] time_q;
	logic [1:0]        status_q [NUM_IDS];
	logic [ID_W-1:0]   sel_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [ID_W-1:0]   head;
	logic [ID_W-1:0]   st_addr;
	logic [1:0]        st_rd;
	logic              out_free;
	logic              keep_run;
	logic              rot_keep;
	logic [QIDX_W-1:0] tail_idx;
	logic [QIDX_W-1:0] last_idx;
	logic              count_full;
	out_item_t         pay;

	assign head       = queue_q[0];
	assign st_addr    = cmd.st_addr_run ? run_q : sel_q;
	assign st_rd      = status_q[st_addr];
	assign out_free   = !out_valid_q || !rsp_stall;
	assign keep_run   = rvalid_q && (sel_q == run_q);
	assign rot_keep   = (head != item_q.thread_id);
	assign tail_idx   = count_q[QIDX_W-1:0];
	assign last_idx   = tail_idx - 1'b1;
	assign count_full = (count_q == CNT_W'(MAX_THREADS));

	assign stat.func       = item_q.func;
	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = count_full;
	assign stat.time_le1   = (time_q <= TIME_W'(1));
	assign stat.run_is_tid = rvalid_q && (run_q == item_q.thread_id);
	assign stat.rem_zero   = (rem_q == '0);
	assign stat.st_zombie  = (st_rd == ST_ZOMBIE);
	assign stat.out_free   = out_free;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Result payload for the current emit code.
	always_comb begin
		pay = '0;
		case (cmd.emit)
			EM_RESULT: begin
				pay.subject_thread = rvalid_q ? run_q : '0;
				pay.last           = 1'b1;
			end
			EM_REJECT: begin
				pay.event_kind     = EV_REJECT;
				pay.subject_thread = item_q.thread_id;
				pay.last           = 1'b1;
			end
			EM_DESTROY: begin
				pay.event_kind     = EV_DESTROY;
				pay.subject_thread = sel_q;
			end
			EM_FINISH: begin
				pay.last = 1'b1;
				if (keep_run) begin
					pay.subject_thread = run_q;
				end else begin
					pay.event_kind      = EV_SWITCH;
					pay.subject_thread  = sel_q;
					pay.previous_thread = rvalid_q ? run_q : '0;
					pay.previous_valid  = rvalid_q;
				end
			end
			default: pay = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req;
		end
		if (cmd.emit != EM_NONE) begin
			out_q <= pay;
		end
		if (cmd.pop_sel) begin
			sel_q <= head;
		end else if (cmd.sel_empty) begin
			sel_q <= (rvalid_q && (st_rd == ST_RUNNABLE)) ? run_q : idle_q;
		end
		// Ready queue: shift toward the head on a pop or rotate, append at the tail.
		if (cmd.pop_sel || cmd.rotate) begin
			for (int i = 0; i < MAX_THREADS - 1; i++) begin
				queue_q[i] <= queue_q[i+1];
			end
			if (cmd.rotate && rot_keep) begin
				queue_q[last_idx] <= head;
			end
		end else if (cmd.push_tid) begin
			queue_q[tail_idx] <= item_q.thread_id;
		end else if (cmd.emit == EM_FINISH && !keep_run && rvalid_q && !count_full) begin
			queue_q[tail_idx] <= run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= QUANTUM_RST;
			idle_q      <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			run_q       <= '0;
			rvalid_q    <= 1'b0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_IDS; i++) begin
				status_q[i] <= ST_RUNNABLE;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_QUANTUM: quantum_q <= cfg_data;
					CFG_IDLE:    idle_q    <= cfg_data[ID_W-1:0];
					default:     ;
				endcase
			end
			if (cmd.emit != EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.dec_time && (time_q != '0)) begin
				time_q <= time_q - 1'b1;
			end
			if (cmd.write_status) begin
				status_q[item_q.thread_id] <= item_q.new_status;
			end
			if (cmd.rem_load) begin
				rem_q <= count_q;
			end else if (cmd.rotate) begin
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.clr_rvalid) begin
				rvalid_q <= 1'b0;
			end
			if (cmd.emit == EM_DESTROY && keep_run) begin
				rvalid_q <= 1'b0;
			end
			// Queue occupancy.
			if (cmd.pop_sel || (cmd.rotate && !rot_keep)) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.push_tid) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.emit == EM_FINISH && !keep_run && rvalid_q && !count_full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit == EM_FINISH) begin
				time_q   <= quantum_q;
				run_q    <= sel_q;
				rvalid_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// Round-robin scheduler with a time quantum. Each request transaction
// carries a function code (tick, add thread, remove thread, start, set
// status) and yields one or more response transactions; the last one of a
// request has last set. A tick counts down the quantum and, when it runs
// out, elects the head of the FIFO ready queue; zombies popped on the way
// come out as destroy events. With the queue empty the running thread keeps
// the CPU while runnable, else the idle thread is elected, and a switch
// puts the old thread back at the tail of the queue. One request is worked
// on at a time and req_stall stays high until its final response is loaded
// into the output register. A request is accepted, then dispatched, then
// its response is loaded; an add on a full queue is rejected from the
// dispatch step. An election pops queue entries (each popped zombie and
// the elected thread) through the elect and check steps, or goes straight
// to the finish step when the queue is empty; removing a thread that is
// not running walks the whole queue, one entry per cycle, and then sees
// the walk end. The sequencer in rrts_ctrl and the shifting queue in
// rrts_dp set these steps. Configuration writes (quantum_ticks at index 0,
// idle_thread at index 1) are taken in any cycle but are meant to land while idle.
module round_robin_thread_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  rrts_pkg::in_item_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output rrts_pkg::out_item_t         rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [rrts_pkg::CFG_W-1:0]  cfg_data
);
	import rrts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/rrts_checker.sv =====
// Port-level checks on the scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_thread_scheduler_macros.svh.
`include "round_robin_thread_scheduler_macros.svh"

module rrts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input rrts_pkg::out_item_t         rsp
);
	import rrts_pkg::*;

	// A stalled response transaction holds.
	`RRTS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// Rejects end their request.
	`RRTS_ASSERT_IMP(a_reject_last, clk, arst_n, rsp_valid && (rsp.event_kind == EV_REJECT), rsp.last)
	// A destroy is always followed by the election result.
	`RRTS_ASSERT_IMP(a_destroy_not_last, clk, arst_n, rsp_valid && (rsp.event_kind == EV_DESTROY), !rsp.last)
	// Previous thread only reported on a switch.
	`RRTS_ASSERT_IMP(a_prev_switch, clk, arst_n, rsp_valid && rsp.previous_valid, rsp.event_kind == EV_SWITCH)

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);
